// ===== design/erpt_pkg.sv =====
// Package for the Euler rotation point transform: payload structs, register
// indexes, fixed-point constants and the CORDIC arctangent table.
// No dependencies.
package erpt_pkg;

  localparam int CordicSteps = 16;
  localparam int CordicIters = (CordicSteps < 24) ? CordicSteps : 24;

  localparam logic [2:0] CFG_ANGLE_X = 3'd0;
  localparam logic [2:0] CFG_ANGLE_Y = 3'd1;
  localparam logic [2:0] CFG_ANGLE_Z = 3'd2;
  localparam logic [2:0] CFG_SHIFT_X = 3'd3;
  localparam logic [2:0] CFG_SHIFT_Y = 3'd4;
  localparam logic [2:0] CFG_SHIFT_Z = 3'd5;

  localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
  localparam logic signed [16:0] PI_Q13      = 17'sd25736;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [15:0] ONE_Q14     = 16'sd16384;

  typedef logic signed [15:0] coef_t;
  typedef coef_t [8:0] terms_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic signed [31:0] result_z;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
  } angles_t;

  typedef struct packed {
    logic  done;
    coef_t cos_v;
    coef_t sin_v;
  } trig_t;

  function automatic logic signed [27:0] atan_q24(input logic [4:0] i);
    logic signed [27:0] v;
    case (i)
      5'd0:  v = 28'sd13176795;
      5'd1:  v = 28'sd7778716;
      5'd2:  v = 28'sd4110060;
      5'd3:  v = 28'sd2086331;
      5'd4:  v = 28'sd1047214;
      5'd5:  v = 28'sd524117;
      5'd6:  v = 28'sd262123;
      5'd7:  v = 28'sd131069;
      5'd8:  v = 28'sd65536;
      5'd9:  v = 28'sd32768;
      5'd10: v = 28'sd16384;
      5'd11: v = 28'sd8192;
      5'd12: v = 28'sd4096;
      5'd13: v = 28'sd2048;
      5'd14: v = 28'sd1024;
      5'd15: v = 28'sd512;
      5'd16: v = 28'sd256;
      5'd17: v = 28'sd128;
      5'd18: v = 28'sd64;
      5'd19: v = 28'sd32;
      5'd20: v = 28'sd16;
      5'd21: v = 28'sd8;
      5'd22: v = 28'sd4;
      5'd23: v = 28'sd2;
      default: v = 28'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/erpt_cordic.sv =====
// Iterative rotation-mode CORDIC: one step per cycle, cos and sin in Q1.14.
// Depends on erpt_pkg.
module erpt_cordic import erpt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] angle,
  output trig_t              trig
);

  logic               run_r, run_nxt;
  logic               fin_r, fin_nxt;
  logic               done_r, done_nxt;
  logic               flip_r, flip_nxt;
  logic [4:0]         step_r, step_nxt;
  logic signed [33:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [27:0] z_r, z_nxt;
  coef_t              cos_r, cos_nxt, sin_r, sin_nxt;

  logic signed [16:0] ang_ext, ang_fold;
  logic               fold;
  logic signed [33:0] dx, dy, xr, yr;

  function automatic coef_t clamp_q14(input logic signed [33:0] v, input logic neg);
    coef_t c;
    if (v > 34'sd16384)       c = ONE_Q14;
    else if (v < -34'sd16384) c = -ONE_Q14;
    else                      c = v[15:0];
    return neg ? -c : c;
  endfunction

  always_comb begin
    ang_ext  = {angle[15], angle};
    fold     = (ang_ext > HALF_PI_Q13) || (ang_ext < -HALF_PI_Q13);
    ang_fold = ang_ext;
    if (ang_ext > HALF_PI_Q13) begin
      ang_fold = ang_ext - PI_Q13;
    end else if (ang_ext < -HALF_PI_Q13) begin
      ang_fold = ang_ext + PI_Q13;
    end
    dx = x_r >>> step_r;
    dy = y_r >>> step_r;
    xr = (x_r + 34'sd32768) >>> 16;
    yr = (y_r + 34'sd32768) >>> 16;

    run_nxt  = run_r;
    fin_nxt  = 1'b0;
    done_nxt = done_r;
    flip_nxt = flip_r;
    step_nxt = step_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cos_nxt  = cos_r;
    sin_nxt  = sin_r;
    if (start) begin
      run_nxt  = 1'b1;
      done_nxt = 1'b0;
      flip_nxt = fold;
      step_nxt = 5'd0;
      x_nxt    = GAIN_Q30;
      y_nxt    = 34'sd0;
      z_nxt    = {ang_fold, 11'b0};
    end else if (run_r) begin
      if (!z_r[27]) begin
        x_nxt = x_r - dy;
        y_nxt = y_r + dx;
        z_nxt = z_r - atan_q24(step_r);
      end else begin
        x_nxt = x_r + dy;
        y_nxt = y_r - dx;
        z_nxt = z_r + atan_q24(step_r);
      end
      step_nxt = step_r + 5'd1;
      if (step_r == 5'(CordicIters - 1)) begin
        run_nxt = 1'b0;
        fin_nxt = 1'b1;
      end
    end else if (fin_r) begin
      cos_nxt  = clamp_q14(xr, flip_r);
      sin_nxt  = clamp_q14(yr, flip_r);
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
    end
    flip_r <= flip_nxt;
    step_r <= step_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    cos_r  <= cos_nxt;
    sin_r  <= sin_nxt;
  end

  assign trig = '{done: done_r, cos_v: cos_r, sin_v: sin_r};

endmodule

// ===== design/erpt_term_builder.sv =====
// Sequencer that runs the CORDIC over the three angles, then forms the nine
// Q1.14 rotation terms with a two-stage multiply. Depends on erpt_pkg, erpt_cordic.
module erpt_term_builder import erpt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    rebuild,
  input  angles_t angles,
  output logic    busy,
  output terms_t  terms
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_TRIG  = 2'd1;
  localparam logic [1:0] ST_TERMS = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [1:0] aidx_r, aidx_nxt;
  logic [3:0] tidx_r, tidx_nxt;
  logic       start_r, start_nxt;
  logic       mv_r, mv_nxt;
  logic [3:0] midx_r;
  coef_t      cx_r, sx_r, cy_r, sy_r, cz_r, sz_r;
  terms_t     terms_r;

  logic signed [15:0] cur_angle;
  trig_t              trig;

  coef_t              a, b, c, d, e;
  logic               neg;
  logic signed [33:0] m1_r, m2_r;
  coef_t              c_r;
  logic signed [50:0] sum;

  erpt_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .angle (cur_angle),
    .trig  (trig)
  );

  always_comb begin
    case (aidx_r)
      2'd0:    cur_angle = angles.angle_x;
      2'd1:    cur_angle = angles.angle_y;
      default: cur_angle = angles.angle_z;
    endcase
  end

  // term = (a*b)*c + (+/-)(d*e) << 14; c = 0 where only the second product is used
  always_comb begin
    a = cx_r; b = sy_r; c = 16'sd0; d = cy_r; e = cz_r; neg = 1'b0;
    case (tidx_r)
      4'd0: begin a = cy_r; b = cz_r; c = 16'sd0; d = cy_r; e = cz_r; neg = 1'b0; end
      4'd1: begin a = sx_r; b = sy_r; c = cz_r; d = cx_r; e = sz_r; neg = 1'b1; end
      4'd2: begin a = cx_r; b = sy_r; c = cz_r; d = sx_r; e = sz_r; neg = 1'b0; end
      4'd3: begin a = cy_r; b = sz_r; c = 16'sd0; d = cy_r; e = sz_r; neg = 1'b0; end
      4'd4: begin a = sx_r; b = sy_r; c = sz_r; d = cx_r; e = cz_r; neg = 1'b0; end
      4'd5: begin a = cx_r; b = sy_r; c = sz_r; d = sx_r; e = cz_r; neg = 1'b1; end
      4'd6: begin a = sy_r; b = sy_r; c = 16'sd0; d = sy_r; e = ONE_Q14; neg = 1'b1; end
      4'd7: begin a = sx_r; b = cy_r; c = 16'sd0; d = sx_r; e = cy_r; neg = 1'b0; end
      4'd8: begin a = cx_r; b = cy_r; c = 16'sd0; d = cx_r; e = cy_r; neg = 1'b0; end
      default: begin a = 16'sd0; b = 16'sd0; c = 16'sd0; d = 16'sd0; e = 16'sd0; end
    endcase
  end

  always_comb begin
    sum = m1_r * c_r + (m2_r <<< 14) + 51'sd134217728;
  end

  always_comb begin
    state_nxt = state_r;
    aidx_nxt  = aidx_r;
    tidx_nxt  = tidx_r;
    start_nxt = 1'b0;
    mv_nxt    = 1'b0;
    if (rebuild) begin
      state_nxt = ST_TRIG;
      aidx_nxt  = 2'd0;
      start_nxt = 1'b1;
    end else begin
      case (state_r)
        ST_IDLE: ;
        ST_TRIG: begin
          if (trig.done && !start_r) begin
            if (aidx_r == 2'd2) begin
              state_nxt = ST_TERMS;
              tidx_nxt  = 4'd0;
            end else begin
              aidx_nxt  = aidx_r + 2'd1;
              start_nxt = 1'b1;
            end
          end
        end
        ST_TERMS: begin
          if (tidx_r <= 4'd8) begin
            mv_nxt   = 1'b1;
            tidx_nxt = tidx_r + 4'd1;
          end else if (!mv_r) begin
            state_nxt = ST_IDLE;
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      aidx_r  <= 2'd0;
      tidx_r  <= 4'd0;
      start_r <= 1'b0;
      mv_r    <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        terms_r[k] <= (k % 4 == 0) ? ONE_Q14 : 16'sd0;
      end
    end else begin
      state_r <= state_nxt;
      aidx_r  <= aidx_nxt;
      tidx_r  <= tidx_nxt;
      start_r <= start_nxt;
      mv_r    <= mv_nxt;
      if (mv_r && !rebuild) begin
        terms_r[midx_r] <= sum[43:28];
      end
    end
    if (state_r == ST_TRIG && trig.done && !start_r) begin
      case (aidx_r)
        2'd0:    begin cx_r <= trig.cos_v; sx_r <= trig.sin_v; end
        2'd1:    begin cy_r <= trig.cos_v; sy_r <= trig.sin_v; end
        default: begin cz_r <= trig.cos_v; sz_r <= trig.sin_v; end
      endcase
    end
    midx_r <= tidx_r;
    m1_r   <= a * b;
    m2_r   <= neg ? -(d * e) : d * e;
    c_r    <= c;
  end

  assign busy  = (state_r != ST_IDLE) || rebuild;
  assign terms = terms_r;

endmodule

// ===== design/erpt_point_pipe.sv =====
// Three-stage point pipeline: nine products, column sums with translation,
// rounding and saturation. Depends on erpt_pkg.
module erpt_point_pipe import erpt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  point_t             in_data,
  input  terms_t             terms,
  input  logic signed [31:0] shift_x,
  input  logic signed [31:0] shift_y,
  input  logic signed [31:0] shift_z,
  output logic               out_valid,
  input  logic               out_stall,
  output result_t            out_data
);

  logic               v1_r, v2_r, v3_r;
  logic               rdy1, rdy2, rdy3;
  logic signed [47:0] prod_r [9];
  logic signed [51:0] acc_r [3];
  logic signed [51:0] acc_nxt [3];
  logic signed [51:0] shifts [3];
  logic signed [51:0] rnd [3];
  logic [2:0]         sat;
  logic signed [31:0] res [3];
  result_t            out_r;

  assign rdy3     = !v3_r || !out_stall;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    shifts[0] = {{6{shift_x[31]}}, shift_x, 14'b0};
    shifts[1] = {{6{shift_y[31]}}, shift_y, 14'b0};
    shifts[2] = {{6{shift_z[31]}}, shift_z, 14'b0};
    for (int c = 0; c < 3; c++) begin
      acc_nxt[c] = 52'(prod_r[c]) + 52'(prod_r[3 + c]) + 52'(prod_r[6 + c]) + shifts[c];
      rnd[c]     = (acc_r[c] + 52'sd8192) >>> 14;
      sat[c]     = (rnd[c] > 52'sd2147483647) || (rnd[c] < -52'sd2147483648);
      if (rnd[c] > 52'sd2147483647)       res[c] = 32'sh7fffffff;
      else if (rnd[c] < -52'sd2147483648) res[c] = 32'sh80000000;
      else                                res[c] = rnd[c][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
    if (rdy1 && in_valid) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[c]     <= in_data.point_x * terms[c];
        prod_r[3 + c] <= in_data.point_y * terms[3 + c];
        prod_r[6 + c] <= in_data.point_z * terms[6 + c];
      end
    end
    if (rdy2 && v1_r) begin
      for (int c = 0; c < 3; c++) acc_r[c] <= acc_nxt[c];
    end
    if (rdy3 && v2_r) begin
      out_r <= '{result_x: res[0], result_y: res[1], result_z: res[2],
                 saturated: |sat};
    end
  end

  assign out_valid = v3_r;
  assign out_data  = out_r;

endmodule

// ===== design/euler_rotate_point_transform_unit.sv =====
// Top level of the Euler rotation point transform: configuration registers,
// term builder and point pipeline. Depends on erpt_pkg, erpt_term_builder, erpt_point_pipe.
//
//  channel  ports                          transaction when
//  in       in_valid  in_stall  in_data    in_valid && !in_stall
//  out      out_valid out_stall out_data   out_valid && !out_stall
//  cfg      cfg_we cfg_index cfg_wdata     cfg_we (every cycle it is high)
//
// Points: one transaction per cycle when nothing stalls, through registered stages
// (product, column sum, round/saturate stages, each with its own valid).
// Angle write: in_stall is high from the write cycle on, while the shared
// CORDIC runs the three angles and then while the nine terms are built.
// Reset loads the identity matrix and zero translation; no CORDIC pass.
// A stalled output freezes only the stages behind it; bubbles still fill.
module euler_rotate_point_transform_unit import erpt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  point_t      in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output result_t     out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  angles_t            angles_r;
  logic signed [31:0] shift_x_r, shift_y_r, shift_z_r;
  logic               rebuild;
  logic               busy;
  logic               pipe_ready;
  terms_t             terms;

  // any angle write reruns the whole term build with the latest angles
  assign rebuild = cfg_we && (cfg_index == CFG_ANGLE_X || cfg_index == CFG_ANGLE_Y ||
                              cfg_index == CFG_ANGLE_Z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angles_r  <= '0;
      shift_x_r <= '0;
      shift_y_r <= '0;
      shift_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ANGLE_X: angles_r.angle_x <= cfg_wdata[15:0];
        CFG_ANGLE_Y: angles_r.angle_y <= cfg_wdata[15:0];
        CFG_ANGLE_Z: angles_r.angle_z <= cfg_wdata[15:0];
        CFG_SHIFT_X: shift_x_r <= cfg_wdata;
        CFG_SHIFT_Y: shift_y_r <= cfg_wdata;
        CFG_SHIFT_Z: shift_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  erpt_term_builder u_terms (
    .clk     (clk),
    .rst_n   (rst_n),
    .rebuild (rebuild),
    .angles  (angles_r),
    .busy    (busy),
    .terms   (terms)
  );

  erpt_point_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid && !busy),
    .in_ready  (pipe_ready),
    .in_data   (in_data),
    .terms     (terms),
    .shift_x   (shift_x_r),
    .shift_y   (shift_y_r),
    .shift_z   (shift_z_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign in_stall = busy || !pipe_ready;

  // no point enters while terms are being rebuilt
  assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> in_stall)
    else $error("point accepted during term rebuild");

  // an angle write always starts a rebuild
  assert property (@(posedge clk) disable iff (!rst_n)
    rebuild |=> busy)
    else $error("angle write did not start rebuild");

  // saturation flag only with a clipped coordinate
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |->
      (out_data.result_x == 32'sh7fffffff || out_data.result_x == 32'sh80000000 ||
       out_data.result_y == 32'sh7fffffff || out_data.result_y == 32'sh80000000 ||
       out_data.result_z == 32'sh7fffffff || out_data.result_z == 32'sh80000000))
    else $error("saturated flag without clipped result");

endmodule

// ===== bench/erpt_scoreboard.sv =====
// Checker for the Euler rotation point transform: follows register writes,
// predicts each point's result and compares it with what leaves the block.
// Depends on erpt_pkg.
`timescale 1ns / 100ps

module erpt_scoreboard import erpt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  point_t      in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  result_t     out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          err_count,
  output int          pending,
  output int          checked,
  output int          sat_seen
);

  localparam longint ArcTab [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};

  logic signed [15:0] ang_x, ang_y, ang_z;
  logic signed [31:0] off_x, off_y, off_z;
  logic signed [15:0] rot [9];
  result_t            want_q [$];

  function automatic void sin_cos(input logic signed [15:0] a,
                                  output longint cv, output longint sv);
    longint ang, x, y, z, t;
    bit     flip;
    ang  = a;
    flip = 0;
    x    = 652032874;
    y    = 0;
    if (ang > 12868) begin
      ang -= 25736; flip = 1;
    end else if (ang < -12868) begin
      ang += 25736; flip = 1;
    end
    z = ang * 2048;
    for (int i = 0; i < CordicIters; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); z -= ArcTab[i];
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); z += ArcTab[i];
      end
      x = t;
    end
    cv = (x + 32768) >>> 16;
    sv = (y + 32768) >>> 16;
    if (cv > 16384) cv = 16384;
    if (cv < -16384) cv = -16384;
    if (sv > 16384) sv = 16384;
    if (sv < -16384) sv = -16384;
    if (flip) begin
      cv = -cv; sv = -sv;
    end
  endfunction

  function automatic logic signed [15:0] to_q14(input longint v);
    longint r;
    r = (v + (64'sd1 <<< 27)) >>> 28;
    return r[15:0];
  endfunction

  // rebuild the nine rotation terms from the three held angles
  task automatic rebuild_rotation();
    longint cx, sx, cy, sy, cz, sz, up;
    up = 16384;
    sin_cos(ang_x, cx, sx);
    sin_cos(ang_y, cy, sy);
    sin_cos(ang_z, cz, sz);
    rot[0] = to_q14(cy * cz * up);
    rot[1] = to_q14(sx * sy * cz - cx * sz * up);
    rot[2] = to_q14(cx * sy * cz + sx * sz * up);
    rot[3] = to_q14(cy * sz * up);
    rot[4] = to_q14(sx * sy * sz + cx * cz * up);
    rot[5] = to_q14(cx * sy * sz - sx * cz * up);
    rot[6] = to_q14(-sy * up * up);
    rot[7] = to_q14(sx * cy * up);
    rot[8] = to_q14(cx * cy * up);
  endtask

  function automatic logic signed [31:0] coord(input point_t p, input int c,
                                               input logic signed [31:0] off,
                                               inout bit clip);
    longint acc, r;
    acc = longint'(p.point_x) * rot[c] + longint'(p.point_y) * rot[3 + c]
        + longint'(p.point_z) * rot[6 + c] + longint'(off) * 16384;
    r = (acc + 8192) >>> 14;
    if (r > 64'sd2147483647) begin
      r = 64'sd2147483647; clip = 1;
    end
    if (r < -64'sd2147483648) begin
      r = -64'sd2147483648; clip = 1;
    end
    return r[31:0];
  endfunction

  function automatic result_t transform_point(input point_t p);
    result_t q;
    bit      clip;
    clip       = 0;
    q.result_x = coord(p, 0, off_x, clip);
    q.result_y = coord(p, 1, off_y, clip);
    q.result_z = coord(p, 2, off_z, clip);
    q.saturated = clip;
    return q;
  endfunction

  assign pending = want_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      ang_x = 0; ang_y = 0; ang_z = 0;
      off_x = 0; off_y = 0; off_z = 0;
      for (int i = 0; i < 9; i++) rot[i] = (i % 4 == 0) ? 16'sd16384 : 16'sd0;
      want_q.delete();
      err_count <= 0;
      checked   <= 0;
      sat_seen  <= 0;
    end else begin
      // writes come only while idle, so blocking updates are safe here
      if (cfg_we) begin
        case (cfg_index)
          CFG_ANGLE_X: begin ang_x = cfg_wdata[15:0]; rebuild_rotation(); end
          CFG_ANGLE_Y: begin ang_y = cfg_wdata[15:0]; rebuild_rotation(); end
          CFG_ANGLE_Z: begin ang_z = cfg_wdata[15:0]; rebuild_rotation(); end
          CFG_SHIFT_X: off_x = cfg_wdata;
          CFG_SHIFT_Y: off_y = cfg_wdata;
          CFG_SHIFT_Z: off_z = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) want_q.push_back(transform_point(in_data));
      if (out_valid && !out_stall) begin
        if (want_q.size() == 0) begin
          $display("%0t: result with nothing expected: %h", $time, out_data);
          err_count <= err_count + 1;
        end else begin
          result_t w;
          w = want_q.pop_front();
          checked <= checked + 1;
          if (w.saturated) sat_seen <= sat_seen + 1;
          if (w.result_x !== out_data.result_x || w.result_y !== out_data.result_y ||
              w.result_z !== out_data.result_z || w.saturated !== out_data.saturated) begin
            $display("%0t: mismatch exp x=%0d y=%0d z=%0d sat=%0b", $time,
                     w.result_x, w.result_y, w.result_z, w.saturated);
            $display("%0t:          got x=%0d y=%0d z=%0d sat=%0b", $time,
                     out_data.result_x, out_data.result_y, out_data.result_z,
                     out_data.saturated);
            err_count <= err_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== bench/euler_rotate_point_transform_unit_tb.sv =====
// Testbench top for the Euler rotation point transform: makes point traffic
// and register writes, applies output backpressure, gives the verdict.
// Depends on erpt_pkg, euler_rotate_point_transform_unit, erpt_scoreboard.
`timescale 1ns / 100ps

module euler_rotate_point_transform_unit_tb import erpt_pkg::*;;

  localparam int CycleLimit = 400000;
  // CORDIC pass for three angles plus term build, with margin
  localparam int RebuildWait = 3 * (CordicIters + 3) + 11 + 40;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  point_t      in_data = '0;
  logic        out_valid;
  logic        out_stall = 0;
  result_t     out_data;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  int          err_count, pending, checked, sat_seen;
  int          cycles = 0;
  int          phases = 0;
  int          stall_mode = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  euler_rotate_point_transform_unit u_dut (.*);

  erpt_scoreboard u_check (.*);

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("euler_rotate_point_transform_unit_tb: done, errors");
      $finish;
    end
  end

  // receiver backpressure: one of four modes, redrawn at random periodically
  // (free flow, light random, heavy random, long stall runs)
  always @(posedge clk) begin
    if (cycles % 128 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 2);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ((cycles / 9) % 3 == 0);
    endcase
  end

  // one transaction; valid stays up across a burst, drops for the gaps
  task automatic send_point(input point_t p);
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (RebuildWait) @(posedge clk);
  endtask

  task automatic set_transform(input logic [15:0] ax, ay, az,
                               input logic [31:0] sx, sy, sz);
    drain();
    write_reg(CFG_ANGLE_X, {{16{ax[15]}}, ax});
    write_reg(CFG_ANGLE_Y, {{16{ay[15]}}, ay});
    write_reg(CFG_ANGLE_Z, {{16{az[15]}}, az});
    write_reg(CFG_SHIFT_X, sx);
    write_reg(CFG_SHIFT_Y, sy);
    write_reg(CFG_SHIFT_Z, sz);
    phases++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
      2: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
      default: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 255)
                                           : 32'h8000_0000 + $urandom_range(0, 255);
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 16'(12868 + $urandom_range(0, 2) - 1);
      2: return 16'(-12868 + $urandom_range(0, 2) - 1);
      default: return 16'($urandom_range(0, 51472) - 25736);
    endcase
  endfunction

  task automatic send_random(input int n);
    point_t p;
    for (int i = 0; i < n; i++) begin
      p.point_x = rand_coord();
      p.point_y = rand_coord();
      p.point_z = rand_coord();
      send_point(p);
    end
  endtask

  initial begin
    point_t p;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity after reset: coordinate extremes pass through
    p = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0};
    send_point(p);
    p = '{32'sh8000_0000, 32'sh7fff_ffff, 32'shffff_ffff};
    send_point(p);
    p = '{32'sh0001_0000, 32'sh0, 32'sh0};
    send_point(p);
    send_random(4);

    // angles beyond half pi, beyond pi, and the 16-bit extremes; full shifts
    set_transform(16'sd12869, -16'sd12869, 16'sd25736,
                  32'h7fff_ffff, 32'h8000_0000, 32'h0);
    p = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
    send_point(p);
    p = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    send_point(p);
    send_random(4);
    set_transform(16'sh7fff, 16'sh8000, -16'sd25736,
                  32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    p = '{32'sh0, 32'sh0, 32'sh0};
    send_point(p);
    send_random(5);

    // an unused register index does nothing
    drain();
    write_reg(3'd6, 32'hffff_ffff);
    write_reg(3'd7, 32'h1234_5678);
    send_random(3);

    // random settings and streams
    for (int ph = 0; ph < 12; ph++) begin
      set_transform(rand_angle(), rand_angle(), rand_angle(),
                    $urandom_range(0, 1) ? $urandom() : rand_coord(),
                    $urandom_range(0, 1) ? $urandom() : rand_coord(),
                    $urandom_range(0, 1) ? $urandom() : rand_coord());
      send_random(35);
      if (ph == 5) drain();   // sender holds off until all results are back
      send_random(35);
    end

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d transform settings, %0d results checked, %0d saturated",
             phases, checked, sat_seen);
    if (err_count == 0 && pending == 0) begin
      $display("euler_rotate_point_transform_unit_tb: done, clean");
    end else begin
      $display("euler_rotate_point_transform_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
